// ----- rtl/codepoint_to_utf8_bytes_defines.svh -----
// Assertion macros for the code point to UTF-8 encoder.
`ifndef CODEPOINT_TO_UTF8_BYTES_DEFINES_SVH
`define CODEPOINT_TO_UTF8_BYTES_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define C2U8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c2u8 check failed");

// Next-cycle implication, disabled during reset.
`define C2U8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c2u8 check failed");

`endif

// ----- rtl/c2u8_pkg.sv -----
// Shared types and constants for the code point to UTF-8 encoder.
`timescale 1ns / 1ps
package c2u8_pkg;

  localparam int CP_W    = 21;
  localparam int BYTE_W  = 8;
  localparam int MAX_LEN = 6;
  localparam int IDX_W   = 3;
  localparam int MODE_W  = 2;

  localparam int MODE_NUL_BIT  = 0;
  localparam int MODE_CESU_BIT = 1;

  localparam logic [CP_W-1:0] LIMIT_1B   = 21'd128;
  localparam logic [CP_W-1:0] LIMIT_2B   = 21'd2048;
  localparam logic [CP_W-1:0] LIMIT_3B   = 21'd65536;
  localparam logic [CP_W-1:0] SUPP_BASE  = 21'h10000;

  localparam logic [BYTE_W-1:0] LEAD_2B  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3B  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4B  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT     = 8'h80;
  localparam logic [BYTE_W-1:0] SURR_LD  = 8'hED;
  localparam logic [BYTE_W-1:0] SURR_HI  = 8'hA0;
  localparam logic [BYTE_W-1:0] SURR_LO  = 8'hB0;

  // Register byte addresses (bit 2 selects the register slot).
  localparam logic REG_MODE_SLOT = 1'b0;

  typedef struct packed {
    logic [MAX_LEN-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]               last_idx;
  } seq_t;

endpackage

// ----- rtl/c2u8_enc.sv -----
// Input register stage: encodes one code point into a byte sequence.
`timescale 1ns / 1ps
module c2u8_enc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [c2u8_pkg::MODE_W-1:0] mode,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [c2u8_pkg::CP_W-1:0]   in_code_point,
  output logic                        seq_valid,
  input  logic                        seq_ready,
  output c2u8_pkg::seq_t              seq
);
  import c2u8_pkg::*;

  logic             seq_valid_r;
  seq_t             seq_r;
  seq_t             seq_nxt;
  logic [CP_W-1:0]  v;

  assign in_ready  = !seq_valid_r || seq_ready;
  assign seq_valid = seq_valid_r;
  assign seq       = seq_r;

  always_comb begin
    v = in_code_point - SUPP_BASE;
    seq_nxt = '0;
    if (mode[MODE_NUL_BIT] && in_code_point == '0) begin
      seq_nxt.bytes[0] = LEAD_2B;
      seq_nxt.bytes[1] = CONT;
      seq_nxt.last_idx = 3'd1;
    end else if (in_code_point < LIMIT_1B) begin
      seq_nxt.bytes[0] = {1'b0, in_code_point[6:0]};
      seq_nxt.last_idx = 3'd0;
    end else if (in_code_point < LIMIT_2B) begin
      seq_nxt.bytes[0] = LEAD_2B | {3'b000, in_code_point[10:6]};
      seq_nxt.bytes[1] = CONT | {2'b00, in_code_point[5:0]};
      seq_nxt.last_idx = 3'd1;
    end else if (in_code_point < LIMIT_3B) begin
      seq_nxt.bytes[0] = LEAD_3B | {4'b0000, in_code_point[15:12]};
      seq_nxt.bytes[1] = CONT | {2'b00, in_code_point[11:6]};
      seq_nxt.bytes[2] = CONT | {2'b00, in_code_point[5:0]};
      seq_nxt.last_idx = 3'd2;
    end else if (mode[MODE_CESU_BIT]) begin
      seq_nxt.bytes[0] = SURR_LD;
      seq_nxt.bytes[1] = SURR_HI | {4'b0000, v[19:16]};
      seq_nxt.bytes[2] = CONT | {2'b00, v[15:10]};
      seq_nxt.bytes[3] = SURR_LD;
      seq_nxt.bytes[4] = SURR_LO | {4'b0000, v[9:6]};
      seq_nxt.bytes[5] = CONT | {2'b00, v[5:0]};
      seq_nxt.last_idx = 3'd5;
    end else begin
      seq_nxt.bytes[0] = LEAD_4B | {5'b00000, in_code_point[20:18]};
      seq_nxt.bytes[1] = CONT | {2'b00, in_code_point[17:12]};
      seq_nxt.bytes[2] = CONT | {2'b00, in_code_point[11:6]};
      seq_nxt.bytes[3] = CONT | {2'b00, in_code_point[5:0]};
      seq_nxt.last_idx = 3'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      seq_valid_r <= 1'b1;
    end else if (seq_ready) begin
      seq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seq_r <= seq_nxt;
    end
  end

endmodule

// ----- rtl/c2u8_ser.sv -----
// Output serializer: emits one byte of a held sequence per word.
`timescale 1ns / 1ps
module c2u8_ser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          seq_valid,
  output logic                          seq_ready,
  input  c2u8_pkg::seq_t                seq,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c2u8_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last_byte
);
  import c2u8_pkg::*;

  logic              act_r;
  seq_t              hold_r;
  logic [IDX_W-1:0]  idx_r;
  logic              last;

  assign last          = (idx_r == hold_r.last_idx);
  assign out_valid     = act_r;
  assign out_byte      = hold_r.bytes[idx_r];
  assign out_last_byte = last;
  assign seq_ready     = !act_r || (out_ready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
    end else if (seq_valid && seq_ready) begin
      act_r <= 1'b1;
      idx_r <= '0;
    end else if (act_r && out_ready) begin
      if (last) begin
        act_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_valid && seq_ready) begin
      hold_r <= seq;
    end
  end

endmodule

// ----- rtl/codepoint_to_utf8_bytes.sv -----
// Path: a code point is registered in the encode register, then held in the serializer.
// Throughput: one code point per cycle for 1-byte sequences while out_ready stays high;
//   longer sequences wait on the output serializer emitting one byte a word.
// A second encoded word waits in the encode register while the serializer drains.
// Reset: synchronous, active low; clears both stages and sets mode_r to 0.
`timescale 1ns / 1ps
`include "codepoint_to_utf8_bytes_defines.svh"
module codepoint_to_utf8_bytes (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [c2u8_pkg::CP_W-1:0]     in_code_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c2u8_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last_byte
);
  import c2u8_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              seq_valid;
  logic              seq_ready;
  seq_t              seq;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODE_SLOT) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_MODE_SLOT) begin
      mode_r <= cfg_pwdata[MODE_W-1:0];
    end
  end

  c2u8_enc u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_point (in_code_point),
    .seq_valid     (seq_valid),
    .seq_ready     (seq_ready),
    .seq           (seq)
  );

  c2u8_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .seq_valid     (seq_valid),
    .seq_ready     (seq_ready),
    .seq           (seq),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  // input only stalls behind a pending output word
  `C2U8_ASSERT_NOW(a_stall_has_out, clk, rst_n, !in_ready, out_valid)
  `C2U8_ASSERT_NOW(a_seq_wait_has_out, clk, rst_n, seq_valid && !seq_ready, out_valid)
  // a sequence keeps going until its last byte
  `C2U8_ASSERT_NEXT(a_seq_continues, clk, rst_n, out_valid && out_ready && !out_last_byte,
                    out_valid)
  `C2U8_ASSERT_NEXT(a_drain_empty, clk, rst_n,
                    out_valid && out_ready && out_last_byte && !seq_valid, !out_valid)

endmodule

// ----- tb/sv/tb_codepoint_to_utf8_bytes.sv -----
// Testbench for the code point to UTF-8 encoder: directed, random and backpressure tests.
`timescale 1ns / 1ps
module tb_codepoint_to_utf8_bytes;
  import c2u8_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 27;
  localparam int REPORT_MAX = 10;
  localparam logic [2:0] MODE_REG_ADDR = 3'd0;
  localparam logic [2:0] SPARE_REG_ADDR = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UTF8 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NUL_PAIR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CESU = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] enc_byte;
    logic              is_last;
  } utf8_unit_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [2:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CP_W-1:0]     in_code_point = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last_byte;

  utf8_unit_t          expected_bytes[$];
  utf8_unit_t          head_unit;
  logic [MODE_W-1:0]   mode_shadow = '0;
  bit                  in_gaps_on = 1'b1;
  bit                  out_gaps_on = 1'b1;
  int                  hold_request = 0;
  int                  stall_left = 0;
  int                  fail_count = 0;
  int                  cycle_count = 0;

  codepoint_to_utf8_bytes u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_point(in_code_point),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("codepoint_to_utf8_bytes test failed");
    $finish;
  end

  function automatic void encode_code_point(input logic [CP_W-1:0] cp);
    logic [BYTE_W-1:0] seq [MAX_LEN];
    logic [CP_W-1:0]   v;
    int                n;
    v = cp - SUPP_BASE;
    n = 0;
    if (mode_shadow[MODE_NUL_BIT] && cp == '0) begin
      seq[0] = LEAD_2B;
      seq[1] = CONT;
      n = 2;
    end else if (cp < LIMIT_1B) begin
      seq[0] = {1'b0, cp[6:0]};
      n = 1;
    end else if (cp < LIMIT_2B) begin
      seq[0] = LEAD_2B | {3'b000, cp[10:6]};
      seq[1] = CONT | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp < LIMIT_3B) begin
      seq[0] = LEAD_3B | {4'b0000, cp[15:12]};
      seq[1] = CONT | {2'b00, cp[11:6]};
      seq[2] = CONT | {2'b00, cp[5:0]};
      n = 3;
    end else if (mode_shadow[MODE_CESU_BIT]) begin
      // surrogate pair halves; bit 20 of the offset falls off
      seq[0] = SURR_LD;
      seq[1] = SURR_HI | {4'b0000, v[19:16]};
      seq[2] = CONT | {2'b00, v[15:10]};
      seq[3] = SURR_LD;
      seq[4] = SURR_LO | {4'b0000, v[9:6]};
      seq[5] = CONT | {2'b00, v[5:0]};
      n = 6;
    end else begin
      seq[0] = LEAD_4B | {5'b00000, cp[20:18]};
      seq[1] = CONT | {2'b00, cp[17:12]};
      seq[2] = CONT | {2'b00, cp[11:6]};
      seq[3] = CONT | {2'b00, cp[5:0]};
      n = 4;
    end
    for (int i = 0; i < n; i++) expected_bytes.push_back('{seq[i], i == n - 1});
  endfunction

  function automatic logic [CP_W-1:0] pick_code_point();
    case ($urandom_range(0, 6))
      0: return CP_W'($urandom_range(0, 'h7F));
      1: return CP_W'($urandom_range('h80, 'h7FF));
      2: return CP_W'($urandom_range('h800, 'hFFFF));
      3, 4: return CP_W'($urandom_range('h10000, 'h10FFFF));
      5: return CP_W'($urandom_range(0, 'h1FFFFF));
      default: begin
        case ($urandom_range(0, 8))
          0: return '0;
          1: return CP_W'('h7F);
          2: return CP_W'('h80);
          3: return CP_W'('h7FF);
          4: return CP_W'('h800);
          5: return CP_W'('hFFFF);
          6: return CP_W'('h10000);
          7: return CP_W'('h10FFFF);
          default: return CP_W'('h1FFFFF);
        endcase
      end
    endcase
  endfunction

  task automatic send_code_point(input logic [CP_W-1:0] cp);
    while (in_gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_point <= cp;
    do @(posedge clk); while (!in_ready);
    encode_code_point(cp);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  // write the given register, then read back the mode register
  task automatic write_mode_reg(input logic [2:0] addr, input logic [31:0] data);
    drain_outputs();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == MODE_REG_ADDR) mode_shadow = data[MODE_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= MODE_REG_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {{(32 - MODE_W){1'b0}}, mode_shadow}) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("mode readback: expected %h got %h", mode_shadow, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] mode_word(input logic [MODE_W-1:0] mode);
    return {30'($urandom_range(0, 'h3FFFFFFF)), mode};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected word: byte %h last %b", out_byte, out_last_byte);
      end else begin
        head_unit = expected_bytes.pop_front();
        if (out_byte !== head_unit.enc_byte || out_last_byte !== head_unit.is_last) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: byte exp %h got %h, last exp %b got %b",
                     head_unit.enc_byte, out_byte, head_unit.is_last, out_last_byte);
        end
      end
    end
    if (hold_request != 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !out_gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic test_directed_edges();
    logic [CP_W-1:0] utf8_edges [12];
    utf8_edges = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFFF, 21'hD800,
                   21'hDFFF, 21'h10000, 21'h10FFFF, 21'h110000, 21'h1FFFFF};
    write_mode_reg(MODE_REG_ADDR, mode_word(MODE_UTF8));
    foreach (utf8_edges[i]) send_code_point(utf8_edges[i]);
    // unmapped slot must leave the mode alone
    write_mode_reg(SPARE_REG_ADDR, 32'hFFFF_FFFF);
    send_code_point('0);
    write_mode_reg(MODE_REG_ADDR, mode_word(MODE_NUL_PAIR));
    send_code_point('0);
    send_code_point(21'h1);
    write_mode_reg(MODE_REG_ADDR, mode_word(MODE_CESU));
    send_code_point(21'hFFFF);
    send_code_point(21'h10000);
    send_code_point(21'h10FFFF);
    send_code_point(21'h110000);
    send_code_point(21'h1FFFFF);
    write_mode_reg(MODE_REG_ADDR, mode_word(MODE_BOTH));
    send_code_point('0);
    send_code_point(21'h10000);
    send_code_point(21'h7FF);
  endtask

  task automatic test_random_modes();
    for (int phase = 0; phase < 8; phase++) begin
      write_mode_reg(MODE_REG_ADDR, mode_word(MODE_W'(phase)));
      repeat (35) send_code_point(pick_code_point());
    end
  endtask

  task automatic test_back_to_back();
    write_mode_reg(MODE_REG_ADDR, mode_word(MODE_W'($urandom_range(0, 3))));
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    repeat (40) send_code_point(pick_code_point());
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_output_hold_off();
    write_mode_reg(MODE_REG_ADDR, mode_word(MODE_CESU));
    in_gaps_on = 1'b0;
    hold_request = 150;
    repeat (20) send_code_point(pick_code_point());
    in_gaps_on = 1'b1;
    drain_outputs();
    repeat (15) send_code_point(pick_code_point());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_random_modes();
    test_back_to_back();
    test_output_hold_off();
    drain_outputs();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("codepoint_to_utf8_bytes test passed");
    end else begin
      $display("codepoint_to_utf8_bytes test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/c2u8_pkg.sv
rtl/c2u8_enc.sv
rtl/c2u8_ser.sv
rtl/codepoint_to_utf8_bytes.sv
tb/sv/tb_codepoint_to_utf8_bytes.sv
